@@ hdl/abkf_pkg.sv @@
// ----------------------------------------------------------------------------
// abkf_pkg
// Types, constants and fixed-point helpers shared by the angle/bias Kalman
// filter modules.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;

	localparam logic [CfgIdxW-1:0] CFG_Q_ANGLE  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_Q_GYRO   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_R_ANGLE  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_MAX_BIAS = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MAX_DT   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_MIN_DT   = 3'd5;

	localparam logic [30:0] RST_Q_ANGLE  = 31'd134218;
	localparam logic [30:0] RST_Q_GYRO   = 31'd1342177;
	localparam logic [30:0] RST_R_ANGLE  = 31'd2684355;
	localparam logic [30:0] RST_MAX_BIAS = 31'd327680;
	localparam logic [23:0] RST_MAX_DT   = 24'd335544;
	localparam logic [23:0] RST_MIN_DT   = 24'd16777;
	localparam logic signed [31:0] COV_INIT = 32'sd26844;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK,
		ST_M_RD, ST_W_RD, ST_M_BD, ST_W_BD, ST_INNER, ST_M_ID, ST_W_ID,
		ST_M_QD, ST_W_QD, ST_SUM, ST_GCHK,
		ST_D0_GO, ST_D0_WAIT, ST_D1_GO, ST_D1_WAIT, ST_Y,
		ST_M_K0Y, ST_W_K0Y, ST_M_K1Y, ST_W_K1Y,
		ST_M_K1A, ST_W_K1A, ST_M_K1B, ST_W_K1B,
		ST_M_K0A, ST_W_K0A, ST_M_K0B, ST_W_K0B, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		MUL_RATE_DT, MUL_BB_DT, MUL_INNER_DT, MUL_QG_DT,
		MUL_K0_Y, MUL_K1_Y, MUL_K1_AA, MUL_K1_AB, MUL_K0_AA, MUL_K0_AB
	} mul_sel_t;

	typedef enum logic [4:0] {
		WB_NONE, WB_LOAD, WB_ANGLE_PRED, WB_D, WB_INNER, WB_COV_PRED, WB_BB_PRED,
		WB_S, WB_K0, WB_K1, WB_KZERO, WB_Y, WB_ANGLE_CORR, WB_BIAS,
		WB_BA, WB_BB, WB_AA, WB_AB, WB_OUT
	} wb_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		wb_op_t   wb;
		logic     div_start;
		logic     div_sel;
	} cmd_t;

	typedef struct packed {
		logic short_step;
		logic s_pos;
		logic div_done;
	} sts_t;

	// Round half up, then drop 24 fraction bits (floor of the biased value).
	function automatic logic signed [43:0] rnd24(input logic signed [67:0] p);
		logic signed [67:0] t;
		t = p + 68'sd8388608;
		return t[67:24];
	endfunction

	function automatic logic signed [39:0] rnd28(input logic signed [67:0] p);
		logic signed [67:0] t;
		t = p + 68'sd134217728;
		return t[67:28];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -48'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

@@ hdl/abkf_if.sv @@
// ----------------------------------------------------------------------------
// abkf_in_if / abkf_out_if
// Valid/ready channels for filter input items and result items.
// ----------------------------------------------------------------------------
interface abkf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] meas_angle;
	logic signed [31:0] meas_rate;
	logic        [23:0] step_time;

	modport source (output valid, meas_angle, meas_rate, step_time, input ready);
	modport sink   (input valid, meas_angle, meas_rate, step_time, output ready);
endinterface

interface abkf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_angle;
	logic signed [31:0] est_bias;
	logic               updated;
	logic               bias_clamped;

	modport source (output valid, est_angle, est_bias, updated, bias_clamped, input ready);
	modport sink   (input valid, est_angle, est_bias, updated, bias_clamped, output ready);
endinterface

@@ hdl/abkf_div.sv @@
// ----------------------------------------------------------------------------
// abkf_div
// Radix-2 restoring divider for the gains: round(num * 2^28 / den), half away
// from zero, saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module abkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [32:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	logic        busy_q, first_q, done_q, neg_q, ovf_q;
	logic [4:0]  cnt_q;
	logic [28:0] n_hi_q;
	logic [31:0] w_q;
	logic [32:0] rem_q, den_q;
	logic [31:0] mag;
	logic [60:0] nsum;
	logic [33:0] trial;
	logic        ge;

	always_comb begin
		mag   = num[31] ? 32'(-num) : 32'(num);
		nsum  = {1'b0, mag, 28'b0} + 61'(den >> 1);
		trial = {rem_q, w_q[31]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (busy_q && first_q) begin
				first_q <= 1'b0;
				cnt_q   <= 5'd31;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_hi_q <= nsum[60:32];
			w_q    <= nsum[31:0];
			den_q  <= den;
			neg_q  <= num[31];
		end else if (busy_q && first_q) begin
			// A quotient of 2^32 or more saturates; no need to develop it.
			rem_q <= {4'b0, n_hi_q};
			ovf_q <= {4'b0, n_hi_q} >= den_q;
		end else if (busy_q) begin
			rem_q <= ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
			w_q   <= {w_q[30:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (ovf_q || w_q[31]) ? 32'sh80000000 : -$signed(w_q);
		end else begin
			quot = (ovf_q || w_q[31]) ? 32'sh7FFFFFFF : $signed(w_q);
		end
	end

	assign done = done_q;

endmodule

@@ hdl/abkf_datapath.sv @@
// ----------------------------------------------------------------------------
// abkf_datapath
// Filter state, configuration registers, shared multiplier, gain divider and
// result register.
// ----------------------------------------------------------------------------
module abkf_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abkf_pkg::cmd_t        cmd,
	output abkf_pkg::sts_t        sts,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [30:0]           cfg_data,
	input  logic signed [31:0]    meas_angle,
	input  logic signed [31:0]    meas_rate,
	input  logic        [23:0]    step_time,
	output logic signed [31:0]    est_angle,
	output logic signed [31:0]    est_bias,
	output logic                  updated,
	output logic                  bias_clamped
);
	import abkf_pkg::*;

	logic [30:0] q_angle_q, q_gyro_q, r_angle_q, max_bias_q;
	logic [23:0] max_dt_q, min_dt_q;

	logic signed [31:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [31:0] m_angle_q, rate_q, y_q, k0_q, k1_q;
	logic        [23:0] dt_q;
	logic               short_q, clamped_q;
	logic signed [32:0] d_q, s_q;
	logic signed [34:0] inner_q;
	logic signed [67:0] prod_q;

	logic signed [35:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [43:0] r24;
	logic signed [39:0] r28;
	logic signed [47:0] b_sum, lim;
	logic signed [31:0] div_q;
	logic               div_done;

	abkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel ? ba_q : aa_q),
		.den    (s_q[32:0]),
		.done   (div_done),
		.quot   (div_q)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_RATE_DT:  begin mul_a = 36'(rate_q);  mul_b = {8'b0, dt_q}; end
			MUL_BB_DT:    begin mul_a = 36'(bb_q);    mul_b = {8'b0, dt_q}; end
			MUL_INNER_DT: begin mul_a = 36'(inner_q); mul_b = {8'b0, dt_q}; end
			MUL_QG_DT:    begin mul_a = {5'b0, q_gyro_q}; mul_b = {8'b0, dt_q}; end
			MUL_K0_Y:     begin mul_a = 36'(k0_q); mul_b = y_q;  end
			MUL_K1_Y:     begin mul_a = 36'(k1_q); mul_b = y_q;  end
			MUL_K1_AA:    begin mul_a = 36'(k1_q); mul_b = aa_q; end
			MUL_K1_AB:    begin mul_a = 36'(k1_q); mul_b = ab_q; end
			MUL_K0_AA:    begin mul_a = 36'(k0_q); mul_b = aa_q; end
			MUL_K0_AB:    begin mul_a = 36'(k0_q); mul_b = ab_q; end
			default:      begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		r24   = rnd24(prod_q);
		r28   = rnd28(prod_q);
		b_sum = 48'(bias_q) + 48'(r28);
		lim   = $signed({17'b0, max_bias_q});
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q  <= RST_Q_ANGLE;
			q_gyro_q   <= RST_Q_GYRO;
			r_angle_q  <= RST_R_ANGLE;
			max_bias_q <= RST_MAX_BIAS;
			max_dt_q   <= RST_MAX_DT;
			min_dt_q   <= RST_MIN_DT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_Q_ANGLE:  q_angle_q  <= cfg_data;
				CFG_Q_GYRO:   q_gyro_q   <= cfg_data;
				CFG_R_ANGLE:  r_angle_q  <= cfg_data;
				CFG_MAX_BIAS: max_bias_q <= cfg_data;
				CFG_MAX_DT:   max_dt_q   <= cfg_data[23:0];
				CFG_MIN_DT:   min_dt_q   <= cfg_data[23:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q     <= '0;
			bias_q    <= '0;
			aa_q      <= COV_INIT;
			ab_q      <= '0;
			ba_q      <= '0;
			bb_q      <= COV_INIT;
			short_q   <= 1'b0;
			clamped_q <= 1'b0;
		end else begin
			case (cmd.wb)
				WB_LOAD: begin
					short_q   <= step_time < min_dt_q;
					clamped_q <= 1'b0;
				end
				WB_ANGLE_PRED: ang_q <= sat32(48'(ang_q) + 48'(r24));
				WB_COV_PRED: begin
					aa_q <= sat32(48'(aa_q) + 48'(r24));
					ab_q <= sat32(48'(ab_q) - 48'(d_q));
					ba_q <= sat32(48'(ba_q) - 48'(d_q));
				end
				WB_BB_PRED:    bb_q  <= sat32(48'(bb_q) + 48'(r24));
				WB_ANGLE_CORR: ang_q <= sat32(48'(ang_q) + 48'(r28));
				WB_BIAS: begin
					if (b_sum > lim) begin
						bias_q    <= lim[31:0];
						clamped_q <= 1'b1;
					end else if (b_sum < -lim) begin
						bias_q    <= 32'(-lim);
						clamped_q <= 1'b1;
					end else begin
						bias_q <= b_sum[31:0];
					end
				end
				WB_BA: ba_q <= sat32(48'(ba_q) - 48'(r28));
				WB_BB: bb_q <= sat32(48'(bb_q) - 48'(r28));
				WB_AA: aa_q <= sat32(48'(aa_q) - 48'(r28));
				WB_AB: ab_q <= sat32(48'(ab_q) - 48'(r28));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.wb)
			WB_LOAD: begin
				m_angle_q <= meas_angle;
				rate_q    <= sat32(48'(meas_rate) - 48'(bias_q));
				dt_q      <= (step_time < max_dt_q) ? step_time : max_dt_q;
			end
			WB_D:     d_q <= r24[32:0];
			WB_INNER: inner_q <= 35'(d_q) - 35'(ab_q) - 35'(ba_q)
				+ $signed({4'b0, q_angle_q});
			WB_S:     s_q <= 33'(aa_q) + $signed({2'b0, r_angle_q});
			WB_K0:    k0_q <= div_q;
			WB_K1:    k1_q <= div_q;
			WB_KZERO: begin
				k0_q <= '0;
				k1_q <= '0;
			end
			WB_Y: y_q <= sat32(48'(m_angle_q) - 48'(ang_q));
			WB_OUT: begin
				est_angle    <= ang_q;
				est_bias     <= bias_q;
				updated      <= !short_q;
				bias_clamped <= clamped_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.short_step = short_q;
		sts.s_pos      = s_q > 33'sd0;
		sts.div_done   = div_done;
	end

endmodule

@@ hdl/abkf_ctrl.sv @@
// ----------------------------------------------------------------------------
// abkf_ctrl
// Sequencer for the predict, gain and correct steps; owns the channel
// handshakes and the result slot.
// ----------------------------------------------------------------------------
module abkf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output abkf_pkg::cmd_t cmd,
	input  abkf_pkg::sts_t sts
);
	import abkf_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_CHECK;
			ST_CHECK:   state_d = sts.short_step ? ST_FIN : ST_M_RD;
			ST_M_RD:    state_d = ST_W_RD;
			ST_W_RD:    state_d = ST_M_BD;
			ST_M_BD:    state_d = ST_W_BD;
			ST_W_BD:    state_d = ST_INNER;
			ST_INNER:   state_d = ST_M_ID;
			ST_M_ID:    state_d = ST_W_ID;
			ST_W_ID:    state_d = ST_M_QD;
			ST_M_QD:    state_d = ST_W_QD;
			ST_W_QD:    state_d = ST_SUM;
			ST_SUM:     state_d = ST_GCHK;
			ST_GCHK:    state_d = sts.s_pos ? ST_D0_GO : ST_Y;
			ST_D0_GO:   state_d = ST_D0_WAIT;
			ST_D0_WAIT: if (sts.div_done) state_d = ST_D1_GO;
			ST_D1_GO:   state_d = ST_D1_WAIT;
			ST_D1_WAIT: if (sts.div_done) state_d = ST_Y;
			ST_Y:       state_d = ST_M_K0Y;
			ST_M_K0Y:   state_d = ST_W_K0Y;
			ST_W_K0Y:   state_d = ST_M_K1Y;
			ST_M_K1Y:   state_d = ST_W_K1Y;
			ST_W_K1Y:   state_d = ST_M_K1A;
			ST_M_K1A:   state_d = ST_W_K1A;
			ST_W_K1A:   state_d = ST_M_K1B;
			ST_M_K1B:   state_d = ST_W_K1B;
			ST_W_K1B:   state_d = ST_M_K0A;
			ST_M_K0A:   state_d = ST_W_K0A;
			ST_W_K0A:   state_d = ST_M_K0B;
			ST_M_K0B:   state_d = ST_W_K0B;
			ST_W_K0B:   state_d = ST_FIN;
			ST_FIN:     if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.mul_sel   = MUL_RATE_DT;
		cmd.wb        = WB_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = 1'b0;
		unique case (state_q)
			ST_IDLE:    if (in_valid) cmd.wb = WB_LOAD;
			ST_M_RD:    cmd.mul_sel = MUL_RATE_DT;
			ST_W_RD:    cmd.wb = WB_ANGLE_PRED;
			ST_M_BD:    cmd.mul_sel = MUL_BB_DT;
			ST_W_BD:    cmd.wb = WB_D;
			ST_INNER:   cmd.wb = WB_INNER;
			ST_M_ID:    cmd.mul_sel = MUL_INNER_DT;
			ST_W_ID:    cmd.wb = WB_COV_PRED;
			ST_M_QD:    cmd.mul_sel = MUL_QG_DT;
			ST_W_QD:    cmd.wb = WB_BB_PRED;
			ST_SUM:     cmd.wb = WB_S;
			ST_GCHK:    if (!sts.s_pos) cmd.wb = WB_KZERO;
			ST_D0_GO:   cmd.div_start = 1'b1;
			ST_D0_WAIT: if (sts.div_done) cmd.wb = WB_K0;
			ST_D1_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
			end
			ST_D1_WAIT: if (sts.div_done) cmd.wb = WB_K1;
			ST_Y:       cmd.wb = WB_Y;
			ST_M_K0Y:   cmd.mul_sel = MUL_K0_Y;
			ST_W_K0Y:   cmd.wb = WB_ANGLE_CORR;
			ST_M_K1Y:   cmd.mul_sel = MUL_K1_Y;
			ST_W_K1Y:   cmd.wb = WB_BIAS;
			// The covariance updates are ordered so each old value is read
			// before it is overwritten.
			ST_M_K1A:   cmd.mul_sel = MUL_K1_AA;
			ST_W_K1A:   cmd.wb = WB_BA;
			ST_M_K1B:   cmd.mul_sel = MUL_K1_AB;
			ST_W_K1B:   cmd.wb = WB_BB;
			ST_M_K0A:   cmd.mul_sel = MUL_K0_AA;
			ST_W_K0A:   cmd.wb = WB_AA;
			ST_M_K0B:   cmd.mul_sel = MUL_K0_AB;
			ST_W_K0B:   cmd.wb = WB_AB;
			ST_FIN:     if (slot_free) cmd.wb = WB_OUT;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_div_only_when_s_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> sts.s_pos) else $error("divider started with S <= 0");
	a_accept_goes_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK) else $error("accept did not start item");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb == WB_OUT |-> slot_free) else $error("result overwritten");
	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_D0_WAIT || state_q == ST_D1_WAIT)
		else $error("divider done outside a wait state");

endmodule

@@ hdl/angle_bias_kalman_filter_core.sv @@
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state angle / gyro-bias Kalman filter for one axis.
// ----------------------------------------------------------------------------
// The work is done by one shared 36x32 multiplier (ten products) and a
// one-bit-per-cycle gain divider that runs twice. An item whose step is
// below min_dt skips the predict and correct steps and goes straight to
// its result. When the innovation variance is not positive, both
// divisions are skipped. The core is ready for the next item in the
// cycle after a result is loaded.
// One item is processed at a time; a finished result waits in an output
// register, so the next item is accepted while the result is still unread.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only
// while idle; the core itself does not enforce this.
module angle_bias_kalman_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	abkf_in_if.sink                         in_ch,
	abkf_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [abkf_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [abkf_pkg::CfgDataW-1:0]   cfg_data
);
	import abkf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	abkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	abkf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.meas_angle   (in_ch.meas_angle),
		.meas_rate    (in_ch.meas_rate),
		.step_time    (in_ch.step_time),
		.est_angle    (out_ch.est_angle),
		.est_bias     (out_ch.est_bias),
		.updated      (out_ch.updated),
		.bias_clamped (out_ch.bias_clamped)
	);

endmodule

@@ sim/angle_bias_kalman_filter_core_test.sv @@
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core_test
// Drives angle/rate/step items into the Kalman filter core under random
// flow control, predicts every result with a fixed-point model of the
// filter kept here, and compares each result item in full.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import abkf_pkg::*;

	localparam int IDLE_GAP = 200;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] est_angle;
		logic signed [31:0] est_bias;
		logic               updated;
		logic               bias_clamped;
	} est_t;

	typedef struct {
		logic signed [31:0] meas_angle;
		logic signed [31:0] meas_rate;
		logic        [23:0] step_time;
		logic               known;
		est_t               res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_data;

	abkf_in_if  in_ch ();
	abkf_out_if out_ch ();

	angle_bias_kalman_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Filter state as the hardware should hold it.
	longint f_angle, f_bias, f_aa, f_ab, f_ba, f_bb;
	longint r_qa, r_qg, r_ra, r_mb, r_maxdt, r_mindt;

	est_t est_queue[$];
	int   mismatches;
	int   results_seen;
	int   updates_seen;
	int   clamps_seen;
	int   shorts_seen;
	int   idle_cycles;
	bit   hold_off;

	function automatic longint round_shr(longint p, int s);
		return (p + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Gain quotient rounded half away from zero. The numerator can reach
	// 2^59, which still fits in 64 bits.
	function automatic longint gain_quot(longint num, longint den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag + longint'(den) / 2) / longint'(den);
		if (q > (64'd1 << 33)) begin
			q = 64'd1 << 33;
		end
		return sat((num < 0) ? -longint'(q) : longint'(q));
	endfunction

	task automatic filter_reset();
		f_angle = 0; f_bias = 0;
		f_aa = COV_INIT; f_ab = 0; f_ba = 0; f_bb = COV_INIT;
		r_qa = RST_Q_ANGLE; r_qg = RST_Q_GYRO; r_ra = RST_R_ANGLE;
		r_mb = RST_MAX_BIAS; r_maxdt = RST_MAX_DT; r_mindt = RST_MIN_DT;
	endtask

	function automatic est_t filter_step(logic signed [31:0] ma, logic signed [31:0] mr,
			logic [23:0] st);
		est_t   r;
		longint dt, d, inner, s, y, b, aa_old, ab_old, k0, k1;
		r.bias_clamped = 1'b0;
		if (longint'(st) < r_mindt) begin
			r.est_angle = f_angle[31:0];
			r.est_bias = f_bias[31:0];
			r.updated = 1'b0;
			return r;
		end
		dt = (longint'(st) < r_maxdt) ? longint'(st) : r_maxdt;
		f_angle = sat(f_angle + round_shr(sat(longint'(mr) - f_bias) * dt, 24));
		d = round_shr(dt * f_bb, 24);
		inner = d - f_ab - f_ba + r_qa;
		f_aa = sat(f_aa + round_shr(dt * inner, 24));
		f_ab = sat(f_ab - d);
		f_ba = sat(f_ba - d);
		f_bb = sat(f_bb + round_shr(r_qg * dt, 24));
		s = f_aa + r_ra;
		if (s > 0) begin
			k0 = gain_quot(f_aa <<< 28, s);
			k1 = gain_quot(f_ba <<< 28, s);
		end else begin
			k0 = 0;
			k1 = 0;
		end
		y = sat(longint'(ma) - f_angle);
		f_angle = sat(f_angle + round_shr(k0 * y, 28));
		b = f_bias + round_shr(k1 * y, 28);
		if (b > r_mb) begin
			b = r_mb; r.bias_clamped = 1'b1;
		end
		if (b < -r_mb) begin
			b = -r_mb; r.bias_clamped = 1'b1;
		end
		f_bias = b;
		aa_old = f_aa;
		ab_old = f_ab;
		f_aa = sat(f_aa - round_shr(k0 * aa_old, 28));
		f_ab = sat(f_ab - round_shr(k0 * ab_old, 28));
		f_ba = sat(f_ba - round_shr(k1 * aa_old, 28));
		f_bb = sat(f_bb - round_shr(k1 * ab_old, 28));
		r.est_angle = f_angle[31:0];
		r.est_bias = f_bias[31:0];
		r.updated = 1'b1;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: cycles with no accepted item on either channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > STALL_LIMIT) begin
			$display("watchdog: no progress, %0d results pending", est_queue.size());
			$display("angle_bias_kalman_filter_core: mismatch");
			$finish;
		end
	end

	// Result side: random ready, with a long hold-off on request.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		est_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.est_angle, out_ch.est_bias, out_ch.updated, out_ch.bias_clamped};
			results_seen++;
			if (est_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result item %p", got);
				end
			end else begin
				want = est_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: expected %p, got %p", results_seen, want, got);
					end
				end
				updates_seen += got.updated;
				clamps_seen += got.bias_clamped;
				shorts_seen += !got.updated;
			end
		end
	end

	task automatic send_item(logic signed [31:0] ma, logic signed [31:0] mr,
			logic [23:0] st, bit has_res, est_t res, int gap);
		est_t p;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.meas_angle <= ma;
		in_ch.meas_rate <= mr;
		in_ch.step_time <= st;
		in_ch.valid <= 1'b1;
		p = filter_step(ma, mr, st);
		if (has_res && p !== res) begin
			mismatches++;
			$display("predictor disagrees with table row: %p vs %p", p, res);
		end
		est_queue.push_back(p);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (est_queue.size() != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_Q_ANGLE:  r_qa = val;
			CFG_Q_GYRO:   r_qg = val;
			CFG_R_ANGLE:  r_ra = val;
			CFG_MAX_BIAS: r_mb = val;
			CFG_MAX_DT:   r_maxdt = val[23:0];
			CFG_MIN_DT:   r_mindt = val[23:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'h7FFFFFFF - $urandom_range(0, 3);
			2: return 32'h80000000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
		endcase
	endfunction

	function automatic logic [23:0] rand_step();
		case ($urandom_range(0, 7))
			0: return 24'($urandom);
			1: return r_mindt[23:0] - 24'd1;
			2: return r_mindt[23:0];
			default: return 24'($urandom_range(16000, 400000));
		endcase
	endfunction

	stim_row_t dir_rows[$];

	initial begin
		est_t nores;
		int   gap;
		nores = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.meas_angle = '0; in_ch.meas_rate = '0; in_ch.step_time = '0;
		mismatches = 0; results_seen = 0; updates_seen = 0; clamps_seen = 0;
		shorts_seen = 0; idle_cycles = 0; hold_off = 1'b0;
		filter_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A short step right after reset returns the reset estimates untouched.
		dir_rows.push_back('{32'sd1000, 32'sd1000, 24'd0, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}});
		dir_rows.push_back('{32'sd0, 32'sd0, 24'd16776, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}});
		// Zero measurements at the minimum step keep the estimates at zero.
		dir_rows.push_back('{32'sd0, 32'sd0, 24'd16777, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}});
		dir_rows.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF, 1'b0, nores});
		dir_rows.push_back('{32'sh80000000, 32'sh80000000, 24'hFFFFFF, 1'b0, nores});
		dir_rows.push_back('{32'sh7FFFFFFF, 32'sh80000000, 24'd335544, 1'b0, nores});
		dir_rows.push_back('{32'sh80000000, 32'sh7FFFFFFF, 24'd20000, 1'b0, nores});
		dir_rows.push_back('{32'sh00050000, 32'sh00010000, 24'd335545, 1'b0, nores});
		dir_rows.push_back('{32'shFFFB0000, 32'sh00000000, 24'd100000, 1'b0, nores});
		dir_rows.push_back('{32'sh55555555, 32'shAAAAAAAA, 24'h555555, 1'b0, nores});
		dir_rows.push_back('{32'shAAAAAAAA, 32'sh55555555, 24'hAAAAAA, 1'b0, nores});
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].meas_angle, dir_rows[i].meas_rate, dir_rows[i].step_time,
				dir_rows[i].known, dir_rows[i].res, 0);
		end
		drain();

		// Zero max_dt, zero noise, zero bias limit, r_angle 0 with negative S possible.
		write_reg(CFG_MAX_DT, 31'd0);
		write_reg(CFG_MIN_DT, 31'd0);
		write_reg(CFG_MAX_BIAS, 31'd0);
		write_reg(CFG_Q_ANGLE, 31'd0);
		write_reg(CFG_Q_GYRO, 31'd0);
		write_reg(CFG_R_ANGLE, 31'd0);
		write_reg(3'd7, 31'h7FFFFFFF);
		for (int i = 0; i < 8; i++) begin
			send_item(rand_word(), rand_word(), rand_step(), 1'b0, nores, 0);
		end
		drain();
		// Largest values everywhere except r_angle (1), min_dt equal to max_dt.
		write_reg(CFG_Q_ANGLE, 31'h7FFFFFFF);
		write_reg(CFG_Q_GYRO, 31'h7FFFFFFF);
		write_reg(CFG_R_ANGLE, 31'd1);
		write_reg(CFG_MAX_BIAS, 31'h7FFFFFFF);
		write_reg(CFG_MAX_DT, 31'hFFFFFF);
		write_reg(CFG_MIN_DT, 31'hFFFFFF);
		for (int i = 0; i < 6; i++) begin
			send_item(rand_word(), rand_word(), (i & 1) ? 24'hFFFFFF : 24'($urandom),
				1'b0, nores, 0);
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				write_reg(CFG_Q_ANGLE, RST_Q_ANGLE);
				write_reg(CFG_Q_GYRO, RST_Q_GYRO);
				write_reg(CFG_R_ANGLE, RST_R_ANGLE);
				write_reg(CFG_MAX_BIAS, RST_MAX_BIAS);
				write_reg(CFG_MAX_DT, 31'(RST_MAX_DT));
				write_reg(CFG_MIN_DT, 31'(RST_MIN_DT));
			end else begin
				write_reg(CFG_Q_ANGLE, 31'($urandom_range(0, 1 << (ph * 5))));
				write_reg(CFG_Q_GYRO, 31'($urandom_range(0, 1 << (ph * 5))));
				write_reg(CFG_R_ANGLE,
					(ph == 5) ? 31'($urandom) : 31'($urandom_range(1, 1 << 24)));
				write_reg(CFG_MAX_BIAS, 31'($urandom_range(0, 1 << (ph * 6))));
				write_reg(CFG_MAX_DT, 31'($urandom_range(1, 1 << 20)));
				write_reg(CFG_MIN_DT, 31'($urandom_range(0, 20000)));
			end
			for (int i = 0; i < 270; i++) begin
				if (i == 100 && ph == 1) begin
					hold_off = 1'b1;
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				if (i < 60) begin
					gap = 0;
				end
				send_item(rand_word(), rand_word(), rand_step(), 1'b0, nores, gap);
				if (i == 200) begin
					// Let every outstanding result come back before going on.
					in_ch.valid <= 1'b0;
					while (est_queue.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		$display("ran %0d results: %0d filter updates, %0d short steps, %0d bias clamps",
			results_seen, updates_seen, shorts_seen, clamps_seen);
		if (mismatches == 0 && est_queue.size() == 0) begin
			$display("angle_bias_kalman_filter_core: match");
		end else begin
			$display("angle_bias_kalman_filter_core: mismatch");
		end
		$finish;
	end

endmodule
